// ===== hdl/tccw_pkg.sv =====
package tccw_pkg;

  // Input kinds
  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_DEC  = 2'd1;
  localparam logic [1:0] KIND_HEX  = 2'd2;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_X       = 8'h78;

  localparam logic [7:0] ATTR_RESET = 8'h07;

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int IDX_W  = 11;
  localparam int NUM_W  = 32;
  localparam int DIGITS = 10;
  localparam int BCD_W  = 4 * DIGITS;
  localparam int CNT_W  = 4;
  localparam int ITER_W = 5;

  localparam logic [7:0] HEX_TABLE [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       char_code;
    logic [NUM_W-1:0] number_value;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] cell_index;
    logic [15:0]      cell_word;
    logic             last;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic newline;
    logic ld_char;
    logic ld_dec;
    logic ld_hex;
    logic conv;
    logic strip;
    logic emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] kind;
    logic       is_newline;
    logic       conv_last;
    logic       strip_stop;
    logic       emit_last;
    logic       out_free;
  } status_t;

endpackage

// ===== hdl/tccw_ctrl.sv =====
module tccw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tccw_pkg::status_t status,
  output tccw_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_STRIP,
    ST_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (status.kind)
            tccw_pkg::KIND_CHAR: begin
              if (status.is_newline) begin
                cmd.newline = 1'b1;
              end else begin
                cmd.ld_char = 1'b1;
                state_next  = ST_EMIT;
              end
            end
            tccw_pkg::KIND_DEC: begin
              cmd.ld_dec = 1'b1;
              state_next = ST_CONV;
            end
            tccw_pkg::KIND_HEX: begin
              cmd.ld_hex = 1'b1;
              state_next = ST_EMIT;
            end
            default: ;
          endcase
        end
      end
      ST_CONV: begin
        cmd.conv = 1'b1;
        if (status.conv_last) state_next = ST_STRIP;
      end
      ST_STRIP: begin
        if (status.strip_stop) state_next = ST_EMIT;
        else cmd.strip = 1'b1;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.emit_last) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/tccw_dpath.sv =====
module tccw_dpath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                clk,
  input  logic                rst,
  input  tccw_pkg::in_word_t  in_word,
  input  tccw_pkg::cmd_t      cmd,
  output tccw_pkg::status_t   status,
  input  logic                cfg_valid,
  input  logic [7:0]          cfg_word,
  output logic                out_valid,
  input  logic                out_ready,
  output tccw_pkg::out_word_t out_word
);

  localparam int BW = tccw_pkg::BCD_W;

  logic [7:0]                    attribute;
  logic [tccw_pkg::ROW_W-1:0]    row;
  logic [tccw_pkg::COL_W-1:0]    col;
  logic [tccw_pkg::NUM_W-1:0]    bin;
  logic [BW-1:0]                 digits;
  logic [tccw_pkg::ITER_W-1:0]   iter;
  logic [tccw_pkg::CNT_W-1:0]    cnt;
  logic [1:0]                    prefix;
  logic                          char_mode;
  logic [7:0]                    char_reg;

  logic [BW-1:0]                 bcd_adj;
  logic [7:0]                    emit_char;
  logic [7:0]                    col_inc;
  logic [5:0]                    row_inc;
  logic [tccw_pkg::ROW_W-1:0]    row_wrap;
  logic [11:0]                   index_full;

  // add-3 correction on every BCD digit before the shift
  always_comb begin
    for (int i = 0; i < tccw_pkg::DIGITS; i++) begin
      if (digits[4*i +: 4] >= 4'd5) bcd_adj[4*i +: 4] = digits[4*i +: 4] + 4'd3;
      else bcd_adj[4*i +: 4] = digits[4*i +: 4];
    end
  end

  always_comb begin
    priority if (prefix == 2'd2) begin
      emit_char = tccw_pkg::CHAR_ZERO;
    end else if (prefix == 2'd1) begin
      emit_char = tccw_pkg::CHAR_X;
    end else if (char_mode) begin
      emit_char = char_reg;
    end else begin
      emit_char = tccw_pkg::HEX_TABLE[digits[BW-1 -: 4]];
    end
  end

  assign col_inc    = {1'b0, col} + 8'd1;
  assign row_inc    = {1'b0, row} + 6'd1;
  assign row_wrap   = (row_inc >= 6'(ROWS)) ? '0 : row_inc[tccw_pkg::ROW_W-1:0];
  assign index_full = 12'(row) * 12'(COLUMNS) + 12'(col);

  assign status.kind       = in_word.kind;
  assign status.is_newline = (in_word.char_code == tccw_pkg::CHAR_NEWLINE);
  assign status.conv_last  = (iter == '1);
  assign status.strip_stop = (cnt <= 4'd1) || (digits[BW-1 -: 4] != 4'd0);
  assign status.emit_last  = (cnt == 4'd1);
  assign status.out_free   = !out_valid || out_ready;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      attribute <= tccw_pkg::ATTR_RESET;
      row       <= '0;
      col       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) attribute <= cfg_word;
      if (cmd.newline) begin
        col <= '0;
        row <= row_wrap;
      end else if (cmd.emit) begin
        if (col_inc >= 8'(COLUMNS)) begin
          col <= '0;
          row <= row_wrap;
        end else begin
          col <= col_inc[tccw_pkg::COL_W-1:0];
        end
      end
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.ld_char) begin
      char_reg  <= in_word.char_code;
      char_mode <= 1'b1;
      prefix    <= 2'd0;
      cnt       <= 4'd1;
    end else if (cmd.ld_dec) begin
      bin       <= in_word.number_value;
      digits    <= '0;
      iter      <= '0;
      char_mode <= 1'b0;
      prefix    <= 2'd0;
      cnt       <= 4'(tccw_pkg::DIGITS);
    end else if (cmd.ld_hex) begin
      digits    <= {in_word.number_value, 8'h00};
      char_mode <= 1'b0;
      prefix    <= 2'd2;
      cnt       <= 4'(tccw_pkg::DIGITS);
    end else if (cmd.conv) begin
      digits <= {bcd_adj[BW-2:0], bin[tccw_pkg::NUM_W-1]};
      bin    <= {bin[tccw_pkg::NUM_W-2:0], 1'b0};
      iter   <= iter + 1'b1;
    end else if (cmd.strip) begin
      digits <= {digits[BW-5:0], 4'h0};
      cnt    <= cnt - 1'b1;
    end else if (cmd.emit) begin
      if (prefix != 2'd0) prefix <= prefix - 1'b1;
      else digits <= {digits[BW-5:0], 4'h0};
      cnt <= cnt - 1'b1;
    end
    if (cmd.emit) begin
      out_word.cell_index <= index_full[tccw_pkg::IDX_W-1:0];
      out_word.cell_word  <= {attribute, emit_char};
      out_word.last       <= (cnt == 4'd1);
    end
  end

endmodule

// ===== hdl/text_console_cell_writer_top.sv =====
// Text console cell writer. Each input word is a character, a 32-bit value
// to print in decimal (no leading zeros, zero as a single '0') or a value to
// print as "0x" plus eight upper-case hex digits. Every printed character
// becomes one output word: the linear cell index (row * COLUMNS + column,
// 11 bits) and a 16-bit cell with the attribute register in the high byte
// and the character code in the low byte; last marks the final cell of an
// input. The cursor advances after each cell, wraps at the end of a row and
// from the last row back to row 0 (no scrolling). Newline moves to column 0
// of the next row and emits nothing; kind 3 is dropped. One input is
// handled at a time. A decimal value first goes through bit-serial
// binary-to-BCD conversion, then its leading zeros are stripped and its
// digits are emitted. Output stalls extend the emit phase.
// The attribute register (reset 0x07) is written through the cfg channel,
// which is always ready; write it only while the block is idle.
module text_console_cell_writer_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                clk,
  input  logic                rst,
  // input words
  input  logic                in_valid,
  output logic                in_ready,
  input  tccw_pkg::in_word_t  in_word,
  // cell writes
  output logic                out_valid,
  input  logic                out_ready,
  output tccw_pkg::out_word_t out_word,
  // attribute register
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_word
);

  tccw_pkg::cmd_t    cmd;
  tccw_pkg::status_t status;

  assign cfg_ready = 1'b1;

  // sequencer: accept, convert, strip leading zeros, emit
  tccw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // cursor, digit shifter, BCD converter and output register
  tccw_dpath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .cmd       (cmd),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_word  (cfg_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule
